### rtl/core/best_y_split_bbox_area_macros.svh
// assertion macros shared by the rtl of the best y-split bounding box block
// no dependencies; define SYNTH to compile the checks away
`ifndef BEST_Y_SPLIT_BBOX_AREA_MACROS_SVH
`define BEST_Y_SPLIT_BBOX_AREA_MACROS_SVH

`ifndef SYNTH
// check sampled on the rising clock edge, suspended while reset is high
`define BYS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("best_y_split_bbox_area: check failed");
// check sampled on every rising clock edge, reset included
`define BYS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("best_y_split_bbox_area: check failed");
`else
`define BYS_ASSERT(name, clk, rst, prop)
`define BYS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### rtl/core/bysplit_pkg.sv
// shared constants and word types of the best y-split bounding box block
// no dependencies
package bysplit_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;

   // fixed widths of the channel fields
   localparam int FIELD_BITS = 16;
   localparam int BEST_BITS  = 33;
   localparam int TOTAL_BITS = 32;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] pos_x;
      logic signed [FIELD_BITS-1:0] pos_y;
      logic                         last_point;
   } req_word_type;

   typedef struct packed {
      logic                         split_found;
      logic signed [FIELD_BITS-1:0] pivot_x;
      logic signed [FIELD_BITS-1:0] pivot_y;
      logic [BEST_BITS-1:0]         best_area;
      logic [TOTAL_BITS-1:0]        total_area;
      logic                         overflow;
   } rsp_word_type;

endpackage

### rtl/core/bysplit_chan_if.sv
// valid/ready channel carrying one word of a chosen payload type
// no dependencies; payload types come from bysplit_pkg at the instance
interface bysplit_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

### rtl/core/best_y_split_bbox_area.sv
// best y-split search over a loaded point set, scored by summed box areas
// points load at one word per cycle while the block is in its load state; after
// the last point the search scans the store for the total box, then for each pivot
// does one scan of the point store through its single read port and, when both
// groups are non-empty, two passes of the shared area unit
// throughput: one point set at a time; reset is synchronous and empties the set
`include "best_y_split_bbox_area_macros.svh"

module best_y_split_bbox_area #(
   parameter int MAX_POINTS = bysplit_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = bysplit_pkg::COORD_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   bysplit_chan_if.sink   req_chan,
   bysplit_chan_if.source rsp_chan
);

   import bysplit_pkg::*;

   localparam int IW         = $clog2(MAX_POINTS);
   localparam int CNTW       = $clog2(MAX_POINTS + 1);
   localparam int CW         = COORD_BITS;
   localparam int AREA_BITS  = 2 * CW;
   localparam int SCORE_BITS = 2 * CW + 1;
   localparam int EXT_BITS   = (CW > FIELD_BITS) ? CW : FIELD_BITS;

   // sequencer states
   typedef enum logic [7:0] {
      ST_LOAD   = 8'b0000_0001,
      ST_BOX    = 8'b0000_0010,
      ST_MSTART = 8'b0000_0100,
      ST_MWAIT  = 8'b0000_1000,
      ST_PIVOT  = 8'b0001_0000,
      ST_SCAN   = 8'b0010_0000,
      ST_NEXT   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   // which box the area unit is working on
   typedef enum logic [1:0] {
      OP_TOTAL,
      OP_LOWER,
      OP_UPPER
   } area_op_type;

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y0;
      logic signed [CW-1:0] y1;
   } box_type;

   // grow a box by one point
   function automatic box_type fold_box(box_type b, logic signed [CW-1:0] x,
                                        logic signed [CW-1:0] y);
      box_type r;
      r    = b;
      if (x < b.x0) r.x0 = x;
      if (x > b.x1) r.x1 = x;
      if (y < b.y0) r.y0 = y;
      if (y > b.y1) r.y1 = y;
      return r;
   endfunction

   // box holding a single point
   function automatic box_type seed_box(logic signed [CW-1:0] x,
                                        logic signed [CW-1:0] y);
      box_type r;
      r.x0 = x;
      r.x1 = x;
      r.y0 = y;
      r.y1 = y;
      return r;
   endfunction

   state_type   state_ff, state_in;
   area_op_type op_ff, op_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] scan_ff, scan_in;
   logic [CNTW-1:0] k_ff, k_in;
   logic [CNTW-1:0] dtag_ff;
   logic [CNTW-1:0] last_idx;
   logic            ovf_ff, ovf_in;
   logic            dv_ff, dv_in;
   logic            piv_pend_ff, piv_pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_data_ff;

   logic req_fire;
   logic room;
   logic issue;
   logic area_start;
   logic load_rsp;

   // input coordinates cut to the coordinate width
   logic [EXT_BITS-1:0]  ext_x;
   logic [EXT_BITS-1:0]  ext_y;
   logic signed [CW-1:0] in_x;
   logic signed [CW-1:0] in_y;

   // point store read side
   logic [IW-1:0]        rd_addr;
   logic [CW-1:0]        rd_x_raw;
   logic [CW-1:0]        rd_y_raw;
   logic signed [CW-1:0] rd_x;
   logic signed [CW-1:0] rd_y;

   // boxes under construction
   box_type all_ff, all_in;
   box_type lo_ff, lo_in;
   box_type up_ff, up_in;
   box_type sel_box;
   logic    lo_ne_ff, lo_ne_in;
   logic    up_ne_ff, up_ne_in;

   logic signed [CW-1:0] piv_x_ff;
   logic signed [CW-1:0] piv_y_ff;

   // search results
   logic [AREA_BITS-1:0]  area;
   logic                  area_done;
   logic [AREA_BITS-1:0]  total_ff;
   logic [AREA_BITS-1:0]  lo_area_ff;
   logic [SCORE_BITS-1:0] best_ff;
   logic [SCORE_BITS-1:0] score;
   logic                  found_ff;
   logic signed [CW-1:0]  best_px_ff;
   logic signed [CW-1:0]  best_py_ff;

   // ------------------------------------------------------------------
   // input word handling
   // ------------------------------------------------------------------
   assign ext_x    = EXT_BITS'($unsigned(req_chan.data.pos_x));
   assign ext_y    = EXT_BITS'($unsigned(req_chan.data.pos_y));
   assign in_x     = $signed(ext_x[CW-1:0]);
   assign in_y     = $signed(ext_y[CW-1:0]);

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;
   // store full: further points are dropped and flagged
   assign room           = (count_ff < CNTW'(MAX_POINTS));
   assign last_idx       = count_ff - CNTW'(1);

   // pivot read in its own state, otherwise the scan pointer
   assign rd_addr = (state_ff == ST_PIVOT) ? k_ff[IW-1:0] : scan_ff[IW-1:0];

   bysplit_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_POINTS)
   ) u_store_x (
      .clock   (clock),
      .wr_en   (req_fire && room),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ($unsigned(in_x)),
      .rd_addr (rd_addr),
      .rd_data (rd_x_raw)
   );

   bysplit_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_POINTS)
   ) u_store_y (
      .clock   (clock),
      .wr_en   (req_fire && room),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ($unsigned(in_y)),
      .rd_addr (rd_addr),
      .rd_data (rd_y_raw)
   );

   assign rd_x = $signed(rd_x_raw);
   assign rd_y = $signed(rd_y_raw);

   // ------------------------------------------------------------------
   // shared area unit
   // ------------------------------------------------------------------
   always_comb begin
      case (op_ff)
         OP_TOTAL: sel_box = all_ff;
         OP_LOWER: sel_box = lo_ff;
         default:  sel_box = up_ff;
      endcase
   end

   bysplit_area #(
      .COORD_BITS (CW)
   ) u_area (
      .clock (clock),
      .reset (reset),
      .start (area_start),
      .x0    (sel_box.x0),
      .x1    (sel_box.x1),
      .y0    (sel_box.y0),
      .y1    (sel_box.y1),
      .area  (area),
      .done  (area_done)
   );

   // sum of the lower and upper box areas for the current pivot
   assign score = SCORE_BITS'(lo_area_ff) + SCORE_BITS'(area);

   // ------------------------------------------------------------------
   // box folding from the store read data
   // ------------------------------------------------------------------
   always_comb begin
      all_in   = all_ff;
      lo_in    = lo_ff;
      up_in    = up_ff;
      lo_ne_in = lo_ne_ff;
      up_ne_in = up_ne_ff;

      // both groups start empty for every pivot
      if (state_ff == ST_PIVOT) begin
         lo_ne_in = 1'b0;
         up_ne_in = 1'b0;
      end

      // whole set box, first point seeds it
      if (dv_ff && (state_ff == ST_BOX)) begin
         if (dtag_ff == '0) begin
            all_in = seed_box(rd_x, rd_y);
         end else begin
            all_in = fold_box(all_ff, rd_x, rd_y);
         end
      end

      // split around the pivot, the pivot itself is skipped
      if (dv_ff && (state_ff == ST_SCAN) && (dtag_ff != k_ff)) begin
         if (rd_y < piv_y_ff) begin
            lo_in    = lo_ne_ff ? fold_box(lo_ff, rd_x, rd_y) : seed_box(rd_x, rd_y);
            lo_ne_in = 1'b1;
         end else begin
            up_in    = up_ne_ff ? fold_box(up_ff, rd_x, rd_y) : seed_box(rd_x, rd_y);
            up_ne_in = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      k_in         = k_ff;
      piv_pend_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      area_start   = 1'b0;
      issue        = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (room) begin
                  count_in = count_ff + CNTW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               // a dropped last point still starts the search
               if (req_chan.data.last_point) begin
                  scan_in  = '0;
                  state_in = ST_BOX;
               end
            end
         end
         ST_BOX: begin
            if (scan_ff < count_ff) begin
               issue   = 1'b1;
               scan_in = scan_ff + CNTW'(1);
            end
            if (dv_ff && (dtag_ff == last_idx)) begin
               op_in    = OP_TOTAL;
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            area_start = 1'b1;
            state_in   = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (area_done) begin
               case (op_ff)
                  OP_TOTAL: begin
                     k_in     = '0;
                     state_in = ST_PIVOT;
                  end
                  OP_LOWER: begin
                     op_in    = OP_UPPER;
                     state_in = ST_MSTART;
                  end
                  default: begin
                     state_in = ST_NEXT;
                  end
               endcase
            end
         end
         ST_PIVOT: begin
            piv_pend_in = 1'b1;
            scan_in     = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               issue   = 1'b1;
               scan_in = scan_ff + CNTW'(1);
            end
            if (dv_ff && (dtag_ff == last_idx)) begin
               // a pivot counts only with both groups non-empty
               if (lo_ne_in && up_ne_in) begin
                  op_in    = OP_LOWER;
                  state_in = ST_MSTART;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (k_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + CNTW'(1);
               state_in = ST_PIVOT;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      dv_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         op_ff        <= OP_TOTAL;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_ff      <= '0;
         k_ff         <= '0;
         dv_ff        <= 1'b0;
         piv_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         scan_ff      <= scan_in;
         k_ff         <= k_in;
         dv_ff        <= dv_in;
         piv_pend_ff  <= piv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      dtag_ff  <= scan_ff;
      all_ff   <= all_in;
      lo_ff    <= lo_in;
      up_ff    <= up_in;
      lo_ne_ff <= lo_ne_in;
      up_ne_ff <= up_ne_in;

      // pivot word comes back in the cycle after its read
      if (piv_pend_ff) begin
         piv_x_ff <= rd_x;
         piv_y_ff <= rd_y;
      end

      if (area_done) begin
         case (op_ff)
            OP_TOTAL: begin
               // best score starts at the whole set box area
               total_ff   <= area;
               best_ff    <= SCORE_BITS'(area);
               found_ff   <= 1'b0;
               best_px_ff <= '0;
               best_py_ff <= '0;
            end
            OP_LOWER: begin
               lo_area_ff <= area;
            end
            default: begin
               // strictly smaller only, so the first pivot keeps a tie
               if (score < best_ff) begin
                  best_ff    <= score;
                  found_ff   <= 1'b1;
                  best_px_ff <= piv_x_ff;
                  best_py_ff <= piv_y_ff;
               end
            end
         endcase
      end

      // output register frees the search from the consumer
      if (load_rsp) begin
         rsp_data_ff.split_found <= found_ff;
         rsp_data_ff.pivot_x     <= FIELD_BITS'(best_px_ff);
         rsp_data_ff.pivot_y     <= FIELD_BITS'(best_py_ff);
         rsp_data_ff.best_area   <= BEST_BITS'(best_ff);
         rsp_data_ff.total_area  <= TOTAL_BITS'(total_ff);
         rsp_data_ff.overflow    <= ovf_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `BYS_ASSERT(a_count_bound, clock, reset, count_ff <= CNTW'(MAX_POINTS))
   `BYS_ASSERT(a_found_better, clock, reset, rsp_valid_ff && rsp_data_ff.split_found |-> rsp_data_ff.best_area < BEST_BITS'(rsp_data_ff.total_area))
   `BYS_ASSERT(a_none_keeps_total, clock, reset, rsp_valid_ff && !rsp_data_ff.split_found |-> rsp_data_ff.pivot_x == '0 && rsp_data_ff.pivot_y == '0 && rsp_data_ff.best_area == BEST_BITS'(rsp_data_ff.total_area))
   `BYS_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid_ff && state_ff == ST_LOAD && count_ff == '0)

endmodule

### rtl/core/bysplit_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module bysplit_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bysplit_area.sv
// shared box area unit: subtract stage, then multiply stage
// uses bysplit_pkg for default widths
module bysplit_area #(
   parameter int COORD_BITS = bysplit_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] x0,
   input  logic signed [COORD_BITS-1:0] x1,
   input  logic signed [COORD_BITS-1:0] y0,
   input  logic signed [COORD_BITS-1:0] y1,
   output logic [2*COORD_BITS-1:0]      area,
   output logic                         done
);

   import bysplit_pkg::*;

   logic signed [COORD_BITS:0] dx_w;
   logic signed [COORD_BITS:0] dy_w;
   logic [COORD_BITS-1:0]      dx_ff;
   logic [COORD_BITS-1:0]      dy_ff;
   logic [2*COORD_BITS-1:0]    prod_in;
   logic [2*COORD_BITS-1:0]    prod_ff;
   logic                       s1_vld_ff;
   logic                       done_ff;

   // max minus min is never negative and fits the coordinate width
   assign dx_w    = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
   assign dy_w    = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
   assign prod_in = dx_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= start;
         done_ff   <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_w[COORD_BITS-1:0];
      dy_ff   <= dy_w[COORD_BITS-1:0];
      prod_ff <= prod_in;
   end

   assign area = prod_ff;
   assign done = done_ff;

endmodule

### sim/best_y_split_bbox_area_tb.sv
// self-checking testbench for the best y-split bounding box block
// depends on bysplit_pkg, bysplit_chan_if and best_y_split_bbox_area from the rtl;
// sends point sets and checks every split word against its own prediction of the search
module best_y_split_bbox_area_tb;
   import bysplit_pkg::*;

   localparam int STORE_DEPTH    = MAX_POINTS_DEF;
   // watchdog limit covers the worst search at a full store, taken several times over
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int RANDOM_POINTS  = 700;
   localparam int IDLE_PERCENT   = 8;
   localparam int DRAIN_CYCLES   = 200;

   // how a set picks its coordinates
   typedef enum int {
      COORD_WIDE,
      COORD_CLUSTER,
      COORD_EXTREME
   } coord_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bysplit_chan_if #(.payload_type(req_word_type)) req_chan ();
   bysplit_chan_if #(.payload_type(rsp_word_type)) rsp_chan ();

   best_y_split_bbox_area dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   // words waiting to be driven, filled up front by the stimulus block
   req_word_type points_to_send[$];
   // predicted split words, oldest first
   rsp_word_type awaited_splits[$];

   // predictor copy of the point store for the set being loaded
   int   set_x[$];
   int   set_y[$];
   logic set_overflow = 1'b0;

   logic req_taken = 1'b0;
   int   points_accepted = 0;
   int   splits_checked = 0;
   int   sets_predicted = 0;
   int   overflow_sets = 0;
   int   splits_predicted = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;

   // long stretch with no idling on either side
   wire steady = (points_accepted >= 300) && (points_accepted < 450);

   function automatic longint box_area(int x0, int x1, int y0, int y1);
      return longint'(x1 - x0) * longint'(y1 - y0);
   endfunction

   // the whole search over the stored set: total box first, then every point as pivot
   function automatic rsp_word_type best_split_of_set();
      rsp_word_type r;
      int     n, ax0, ax1, ay0, ay1;
      int     lx0, lx1, ly0, ly1, ux0, ux1, uy0, uy1, nl, nu;
      int     px, py;
      logic   found;
      longint total, best, score;
      n = set_x.size();
      ax0 = set_x[0]; ax1 = set_x[0];
      ay0 = set_y[0]; ay1 = set_y[0];
      for (int t = 1; t < n; t++) begin
         if (set_x[t] < ax0) ax0 = set_x[t];
         if (set_x[t] > ax1) ax1 = set_x[t];
         if (set_y[t] < ay0) ay0 = set_y[t];
         if (set_y[t] > ay1) ay1 = set_y[t];
      end
      total = box_area(ax0, ax1, ay0, ay1);
      best  = total;
      found = 1'b0;
      px = 0;
      py = 0;
      for (int k = 0; k < n; k++) begin
         nl = 0; nu = 0;
         lx0 = 0; lx1 = 0; ly0 = 0; ly1 = 0;
         ux0 = 0; ux1 = 0; uy0 = 0; uy1 = 0;
         for (int t = 0; t < n; t++) begin
            if (t == k) continue;
            // strictly below the pivot goes low, equal y goes high
            if (set_y[t] < set_y[k]) begin
               if (nl == 0) begin
                  lx0 = set_x[t]; lx1 = set_x[t]; ly0 = set_y[t]; ly1 = set_y[t];
               end else begin
                  if (set_x[t] < lx0) lx0 = set_x[t];
                  if (set_x[t] > lx1) lx1 = set_x[t];
                  if (set_y[t] < ly0) ly0 = set_y[t];
                  if (set_y[t] > ly1) ly1 = set_y[t];
               end
               nl++;
            end else begin
               if (nu == 0) begin
                  ux0 = set_x[t]; ux1 = set_x[t]; uy0 = set_y[t]; uy1 = set_y[t];
               end else begin
                  if (set_x[t] < ux0) ux0 = set_x[t];
                  if (set_x[t] > ux1) ux1 = set_x[t];
                  if (set_y[t] < uy0) uy0 = set_y[t];
                  if (set_y[t] > uy1) uy1 = set_y[t];
               end
               nu++;
            end
         end
         if (nl == 0 || nu == 0) continue;
         score = box_area(lx0, lx1, ly0, ly1) + box_area(ux0, ux1, uy0, uy1);
         // strict compare keeps the first pivot on ties
         if (score < best) begin
            best  = score;
            found = 1'b1;
            px = set_x[k];
            py = set_y[k];
         end
      end
      r.split_found = found;
      r.pivot_x     = px[FIELD_BITS-1:0];
      r.pivot_y     = py[FIELD_BITS-1:0];
      r.best_area   = best[BEST_BITS-1:0];
      r.total_area  = total[TOTAL_BITS-1:0];
      r.overflow    = set_overflow;
      return r;
   endfunction

   // mirror of the store for one accepted word; a last point closes the set
   function automatic void load_point(req_word_type w);
      rsp_word_type r;
      if (set_x.size() < STORE_DEPTH) begin
         set_x.insert(set_x.size(), int'(w.pos_x));
         set_y.insert(set_y.size(), int'(w.pos_y));
      end else begin
         set_overflow = 1'b1;
      end
      if (w.last_point) begin
         r = best_split_of_set();
         awaited_splits.insert(awaited_splits.size(), r);
         sets_predicted++;
         if (r.overflow) overflow_sets++;
         if (r.split_found) splits_predicted++;
         set_x.delete();
         set_y.delete();
         set_overflow = 1'b0;
      end
   endfunction

   function automatic void compare_field(string field, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic void queue_point(int x, int y, logic last);
      req_word_type w;
      w.pos_x      = x[FIELD_BITS-1:0];
      w.pos_y      = y[FIELD_BITS-1:0];
      w.last_point = last;
      points_to_send.insert(points_to_send.size(), w);
   endfunction

   function automatic int pick_coord(coord_mode_type mode, int base);
      int corner;
      case (mode)
         COORD_CLUSTER: begin
            return base + int'($urandom_range(7));
         end
         COORD_EXTREME: begin
            corner = $urandom_range(4);
            case (corner)
               0: return -32768;
               1: return -1;
               2: return 0;
               3: return 1;
               default: return 32767;
            endcase
         end
         default: begin
            return int'($signed(16'($urandom)));
         end
      endcase
   endfunction

   // one random set; sizes past the store drop their tail, last point included
   function automatic void queue_random_set(int size);
      coord_mode_type mode;
      int base_x, base_y, pick;
      pick = $urandom_range(9);
      mode = (pick < 4) ? COORD_WIDE : (pick < 8) ? COORD_CLUSTER : COORD_EXTREME;
      base_x = int'($urandom_range(65528)) - 32768;
      base_y = int'($urandom_range(65528)) - 32768;
      for (int i = 0; i < size; i++)
         queue_point(pick_coord(mode, base_x), pick_coord(mode, base_y), i == size - 1);
   endfunction

   // driver: one new word or a gap per falling edge, valid held until taken
   always @(negedge clock) begin : drive
      logic         next_valid;
      req_word_type next_word;
      next_valid = req_chan.valid;
      next_word  = req_chan.data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         next_valid = 1'b0;
         if (points_to_send.size() > 0 &&
             (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_word  = points_to_send.pop_front();
            next_valid = 1'b1;
         end
      end
      req_chan.valid <= next_valid;
      req_chan.data  <= next_word;
      // receiver stalls at random outside the steady stretch
      rsp_chan.ready <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
   end

   // monitor: both handshakes at the rising edge, plus the no-progress watchdog
   always @(posedge clock) begin : observe
      rsp_word_type want;
      logic         moved;
      moved = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            points_accepted++;
            load_point(req_chan.data);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (awaited_splits.size() == 0) begin
               mismatches++;
               $display("%0t: split word with none expected, actual %p", $time, rsp_chan.data);
            end else begin
               want = awaited_splits.pop_front();
               splits_checked++;
               compare_field("split_found", want.split_found, rsp_chan.data.split_found);
               compare_field("pivot_x", want.pivot_x, rsp_chan.data.pivot_x);
               compare_field("pivot_y", want.pivot_y, rsp_chan.data.pivot_y);
               compare_field("best_area", want.best_area, rsp_chan.data.best_area);
               compare_field("total_area", want.total_area, rsp_chan.data.total_area);
               compare_field("overflow", want.overflow, rsp_chan.data.overflow);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d splits still expected",
                     $time, quiet_cycles, awaited_splits.size());
            $display("best_y_split_bbox_area_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int random_points, set_size, roll;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;

      // directed: single point at the corner, nothing to split
      queue_point(-32768, 32767, 1'b1);
      // two opposite corners: widest total box, neither pivot has both groups
      queue_point(-32768, -32768, 1'b0);
      queue_point(32767, 32767, 1'b1);
      // all on one y: zero total area, every other point lands high
      queue_point(0, 5, 1'b0);
      queue_point(100, 5, 1'b0);
      queue_point(-100, 5, 1'b1);
      // two tight clusters far apart: a clean split exists
      queue_point(0, 0, 1'b0);
      queue_point(1, 1, 1'b0);
      queue_point(100, 100, 1'b0);
      queue_point(101, 101, 1'b1);
      // symmetric square with a center point: two pivots tie, the center pivot scores lowest
      queue_point(0, 0, 1'b0);
      queue_point(0, 10, 1'b0);
      queue_point(10, 0, 1'b0);
      queue_point(10, 10, 1'b0);
      queue_point(5, 5, 1'b1);
      // mixed extremes around zero
      queue_point(32767, -32768, 1'b0);
      queue_point(-32768, 32767, 1'b0);
      queue_point(-1, 0, 1'b0);
      queue_point(0, -1, 1'b0);
      queue_point(1, 1, 1'b1);

      // random sets: first a full store, then most likely one past capacity, then mostly small
      random_points = 0;
      while (random_points < RANDOM_POINTS) begin
         roll = $urandom_range(99);
         if (random_points == 0 || roll < 6)
            set_size = STORE_DEPTH;
         else if (random_points == STORE_DEPTH || roll < 11)
            set_size = STORE_DEPTH + 1 + $urandom_range(2);
         else if (roll < 25)
            set_size = 13 + $urandom_range(27);
         else
            set_size = 1 + $urandom_range(11);
         queue_random_set(set_size);
         random_points += set_size;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last word to go in, then for every split to come back
      while (points_to_send.size() > 0 || req_chan.valid) @(negedge clock);
      while (awaited_splits.size() > 0) @(negedge clock);
      // catch any stray split words after the last expected one
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d points loaded in %0d sets, %0d sets past capacity",
               points_accepted, sets_predicted, overflow_sets);
      $display("%0d split words checked, %0d with a split that beat the total box",
               splits_checked, splits_predicted);
      if (mismatches == 0) begin
         $display("best_y_split_bbox_area_tb OK");
      end else begin
         $display("best_y_split_bbox_area_tb NOT OK");
      end
      $finish;
   end

endmodule
